/* hw/rtl/ctb_pkg.sv */
// ----------------------------------------------------------------------------
// ctb_pkg
// shared types, sizes and codes for the countdown timer bank
// ----------------------------------------------------------------------------
package ctb_pkg;

    // bank sizes (1 to 16 each)
    localparam int FAST_TIMERS = 16;
    localparam int SLOW_TIMERS = 8;

    // field widths
    localparam int COUNT_W  = 32;
    localparam int OPCODE_W = 3;
    localparam int INDEX_W  = 4;
    localparam int SLOT_W   = 4;
    localparam int RELOAD_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [RELOAD_W-1:0] RELOAD_RESET = RELOAD_W'(1000);

    // address widths of the two banks
    localparam int FAST_AW = (FAST_TIMERS > 1) ? $clog2(FAST_TIMERS) : 1;
    localparam int SLOW_AW = (SLOW_TIMERS > 1) ? $clog2(SLOW_TIMERS) : 1;

    // sweep counter must hold the larger bank size itself
    localparam int MAX_TIMERS = (FAST_TIMERS > SLOW_TIMERS) ? FAST_TIMERS : SLOW_TIMERS;
    localparam int CNT_W      = $clog2(MAX_TIMERS + 1);

    typedef logic [COUNT_W-1:0] t_count;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK        = 3'd0,
        OP_RELOAD_FAST = 3'd1,
        OP_RELOAD_SLOW = 3'd2,
        OP_QUERY_FAST  = 3'd3,
        OP_QUERY_SLOW  = 3'd4
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESCALE_SLOT   = 1'd0,
        CFG_PRESCALE_RELOAD = 1'd1
    } t_cfg_reg;

    // write side of a bank
    typedef struct packed {
        logic         we;
        logic [3:0]   addr;
        t_count       data;
    } t_bank_wr;

endpackage

/* hw/rtl/ctb_if.sv */
// ----------------------------------------------------------------------------
// ctb_if
// valid/ready channels of the timer bank: command, response, configuration
// ----------------------------------------------------------------------------
interface ctb_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [ctb_pkg::OPCODE_W-1:0]  opcode;
    logic [ctb_pkg::INDEX_W-1:0]   timer_index;
    logic [ctb_pkg::COUNT_W-1:0]   load_value;

    modport source (output valid, opcode, timer_index, load_value, input ready);
    modport sink   (input valid, opcode, timer_index, load_value, output ready);
endinterface

interface ctb_rsp_if;
    logic valid;
    logic ready;
    logic elapsed;
    logic bad_index;

    modport source (output valid, elapsed, bad_index, input ready);
    modport sink   (input valid, elapsed, bad_index, output ready);
endinterface

interface ctb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ctb_pkg::CFG_IDX_W-1:0]   index;
    logic [ctb_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/ctb_ram.sv */
// ----------------------------------------------------------------------------
// ctb_ram
// one-write one-read timer store, registered read, per-entry valid bits
// ----------------------------------------------------------------------------
module ctb_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ctb_pkg::t_bank_wr     i_wr,
    input  logic [AW-1:0]         i_raddr,
    output ctb_pkg::t_count       o_rdata
);

    ctb_pkg::t_count r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    ctb_pkg::t_count r_rdata;
    logic            r_rvalid;

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_valid[i_wr.addr[AW-1:0]] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

/* hw/rtl/ctb_dec.sv */
// ----------------------------------------------------------------------------
// ctb_dec
// shared zero test and saturating decrement of one timer count
// ----------------------------------------------------------------------------
module ctb_dec (
    input  ctb_pkg::t_count i_count,
    output logic            o_zero,
    output ctb_pkg::t_count o_next
);

    assign o_zero = (i_count == '0);
    assign o_next = o_zero ? '0 : i_count - ctb_pkg::COUNT_W'(1);

endmodule

/* hw/rtl/countdown_timer_bank_with_prescaler.sv */
// ----------------------------------------------------------------------------
// countdown_timer_bank_with_prescaler
// two banks of 32-bit countdown timers walked by one shared decrementer
// ----------------------------------------------------------------------------
// One command item is taken at a time and gives exactly one response item.
// A reload or an out-of-range query answers from the execute state, an
// in-range query after a further check state. A tick sweeps the fast bank
// through the one decrementer at one timer per cycle (read and write-back
// overlapped), then, when the prescaler slot lies inside the fast bank, reads
// the prescaler timer, and when it has expired reloads it and sweeps the slow
// bank the same way. Tick duration is set by the single read port of each bank
// and the one shared decrementer. Config writes are always taken and should
// only be issued while the block is idle. Timers read as zero after reset
// through per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module countdown_timer_bank_with_prescaler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ctb_cmd_if.sink     i_cmd,
    ctb_rsp_if.source   o_rsp,
    ctb_cfg_if.sink     i_cfg
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_EXEC    = 7'b0000010,
        S_FAST    = 7'b0000100,
        S_PRE_RD  = 7'b0001000,
        S_PRE_CHK = 7'b0010000,
        S_SLOW    = 7'b0100000,
        S_QCHK    = 7'b1000000
    } t_state;

    localparam int IDX_CMP_W = ctb_pkg::INDEX_W + 1;
    localparam int SLOT_CMP_W = ctb_pkg::SLOT_W + 1;

    // control state
    t_state                          r_state, n_state;
    logic [ctb_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic                            r_rsp_valid, n_rsp_valid;
    logic [ctb_pkg::SLOT_W-1:0]      r_slot;
    logic [ctb_pkg::RELOAD_W-1:0]    r_reload;

    // latched item and result payload
    logic [ctb_pkg::OPCODE_W-1:0]    r_op;
    logic [ctb_pkg::INDEX_W-1:0]     r_idx;
    ctb_pkg::t_count                 r_val;
    logic                            r_fast_ok, r_slow_ok;
    logic                            r_elapsed, n_elapsed;
    logic                            r_bad, n_bad;

    // bank ports
    ctb_pkg::t_bank_wr               fast_wr, slow_wr;
    logic [ctb_pkg::FAST_AW-1:0]     fast_raddr;
    logic [ctb_pkg::SLOW_AW-1:0]     slow_raddr;
    ctb_pkg::t_count                 fast_rdata, slow_rdata;

    // shared unit
    ctb_pkg::t_count                 dec_in, dec_next;
    logic                            dec_zero;

    logic                            cmd_fire;
    logic                            slot_ok;
    logic [ctb_pkg::CNT_W-1:0]       cnt_m1;
    logic                            sel_slow;

    assign cmd_fire    = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && !r_rsp_valid;
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid     = r_rsp_valid;
    assign o_rsp.elapsed   = r_elapsed;
    assign o_rsp.bad_index = r_bad;

    // no fast timer acts as prescaler when the slot is past the bank
    assign slot_ok = {1'b0, r_slot} < SLOT_CMP_W'(ctb_pkg::FAST_TIMERS);
    assign cnt_m1  = r_cnt - ctb_pkg::CNT_W'(1);

    // decrementer fed by whichever bank is being worked on
    assign sel_slow = (r_state == S_SLOW) ||
                      ((r_state == S_QCHK) && (r_op == ctb_pkg::OP_QUERY_SLOW));
    assign dec_in   = sel_slow ? slow_rdata : fast_rdata;

    ctb_dec u_dec (
        .i_count (dec_in),
        .o_zero  (dec_zero),
        .o_next  (dec_next)
    );

    ctb_ram #(.DEPTH(ctb_pkg::FAST_TIMERS), .AW(ctb_pkg::FAST_AW)) u_fast_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fast_wr),
        .i_raddr (fast_raddr),
        .o_rdata (fast_rdata)
    );

    ctb_ram #(.DEPTH(ctb_pkg::SLOW_TIMERS), .AW(ctb_pkg::SLOW_AW)) u_slow_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (slow_wr),
        .i_raddr (slow_raddr),
        .o_rdata (slow_rdata)
    );

    // sequencer and bank access
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rsp_valid = r_rsp_valid;
        n_elapsed   = r_elapsed;
        n_bad       = r_bad;
        fast_wr     = '0;
        slow_wr     = '0;
        fast_raddr  = r_idx[ctb_pkg::FAST_AW-1:0];
        slow_raddr  = r_idx[ctb_pkg::SLOW_AW-1:0];

        if (r_rsp_valid && o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (cmd_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // default result: nothing elapsed, index fine
                n_elapsed = 1'b0;
                n_bad     = 1'b0;
                n_state   = S_IDLE;
                case (r_op)
                    ctb_pkg::OP_TICK: begin
                        n_cnt   = '0;
                        n_state = S_FAST;
                    end
                    ctb_pkg::OP_RELOAD_FAST: begin
                        fast_wr.we   = r_fast_ok;
                        fast_wr.addr = 4'(r_idx[ctb_pkg::FAST_AW-1:0]);
                        fast_wr.data = r_val;
                        n_bad        = !r_fast_ok;
                        n_rsp_valid  = 1'b1;
                    end
                    ctb_pkg::OP_RELOAD_SLOW: begin
                        slow_wr.we   = r_slow_ok;
                        slow_wr.addr = 4'(r_idx[ctb_pkg::SLOW_AW-1:0]);
                        slow_wr.data = r_val;
                        n_bad        = !r_slow_ok;
                        n_rsp_valid  = 1'b1;
                    end
                    ctb_pkg::OP_QUERY_FAST: begin
                        // read issued on r_idx through the default address
                        if (r_fast_ok) begin
                            n_state = S_QCHK;
                        end else begin
                            n_elapsed   = 1'b1;
                            n_bad       = 1'b1;
                            n_rsp_valid = 1'b1;
                        end
                    end
                    ctb_pkg::OP_QUERY_SLOW: begin
                        if (r_slow_ok) begin
                            n_state = S_QCHK;
                        end else begin
                            n_elapsed   = 1'b1;
                            n_bad       = 1'b1;
                            n_rsp_valid = 1'b1;
                        end
                    end
                    default: begin
                        n_rsp_valid = 1'b1;
                    end
                endcase
            end
            S_FAST: begin
                // read timer r_cnt while writing back timer r_cnt - 1
                fast_raddr = r_cnt[ctb_pkg::FAST_AW-1:0];
                if (r_cnt != '0) begin
                    fast_wr.we   = 1'b1;
                    fast_wr.addr = 4'(cnt_m1[ctb_pkg::FAST_AW-1:0]);
                    fast_wr.data = dec_next;
                end
                if (r_cnt == ctb_pkg::CNT_W'(ctb_pkg::FAST_TIMERS)) begin
                    if (slot_ok) begin
                        n_state = S_PRE_RD;
                    end else begin
                        n_state     = S_IDLE;
                        n_rsp_valid = 1'b1;
                    end
                end else begin
                    n_cnt = r_cnt + ctb_pkg::CNT_W'(1);
                end
            end
            S_PRE_RD: begin
                fast_raddr = r_slot[ctb_pkg::FAST_AW-1:0];
                n_state    = S_PRE_CHK;
            end
            S_PRE_CHK: begin
                // prescaler expired: reload it and step the slow bank
                if (dec_zero) begin
                    fast_wr.we   = 1'b1;
                    fast_wr.addr = 4'(r_slot[ctb_pkg::FAST_AW-1:0]);
                    fast_wr.data = ctb_pkg::COUNT_W'(r_reload);
                    n_cnt        = '0;
                    n_state      = S_SLOW;
                end else begin
                    n_state     = S_IDLE;
                    n_rsp_valid = 1'b1;
                end
            end
            S_SLOW: begin
                slow_raddr = r_cnt[ctb_pkg::SLOW_AW-1:0];
                if (r_cnt != '0) begin
                    slow_wr.we   = 1'b1;
                    slow_wr.addr = 4'(cnt_m1[ctb_pkg::SLOW_AW-1:0]);
                    slow_wr.data = dec_next;
                end
                if (r_cnt == ctb_pkg::CNT_W'(ctb_pkg::SLOW_TIMERS)) begin
                    n_state     = S_IDLE;
                    n_rsp_valid = 1'b1;
                end else begin
                    n_cnt = r_cnt + ctb_pkg::CNT_W'(1);
                end
            end
            S_QCHK: begin
                n_elapsed   = dec_zero;
                n_state     = S_IDLE;
                n_rsp_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rsp_valid <= 1'b0;
            r_slot      <= '0;
            r_reload    <= ctb_pkg::RELOAD_RESET;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rsp_valid <= n_rsp_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    ctb_pkg::CFG_PRESCALE_SLOT: begin
                        r_slot <= i_cfg.data[ctb_pkg::SLOT_W-1:0];
                    end
                    ctb_pkg::CFG_PRESCALE_RELOAD: begin
                        r_reload <= i_cfg.data[ctb_pkg::RELOAD_W-1:0];
                    end
                    default: begin
                        r_slot <= r_slot;
                    end
                endcase
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (cmd_fire) begin
            r_op      <= i_cmd.opcode;
            r_idx     <= i_cmd.timer_index;
            r_val     <= i_cmd.load_value;
            r_fast_ok <= {1'b0, i_cmd.timer_index} < IDX_CMP_W'(ctb_pkg::FAST_TIMERS);
            r_slow_ok <= {1'b0, i_cmd.timer_index} < IDX_CMP_W'(ctb_pkg::SLOW_TIMERS);
        end
        r_elapsed <= n_elapsed;
        r_bad     <= n_bad;
    end

    // checks
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!fast_wr.we && !slow_wr.we))
        else $error("bank written while idle");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_fire |=> (r_state == S_EXEC) && !r_rsp_valid)
        else $error("accepted item not executed");

    a_fast_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FAST) |-> (r_cnt <= ctb_pkg::CNT_W'(ctb_pkg::FAST_TIMERS)))
        else $error("fast sweep ran past bank");

    a_slow_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SLOW) |-> (r_cnt <= ctb_pkg::CNT_W'(ctb_pkg::SLOW_TIMERS)))
        else $error("slow sweep ran past bank");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the countdown timer bank with prescaler
// ----------------------------------------------------------------------------
// A table of directed commands runs first at the reset settings, then several
// random phases, each with its own prescaler slot and reload value. Every
// accepted command is run through a local model of both timer banks. Each
// response is compared in order against the model's output, or against the
// value typed into the table. Both handshake sides pause at random.
// ----------------------------------------------------------------------------
module tb;
    import ctb_pkg::*;

    // opcodes the block must ignore
    localparam logic [OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int DIR_N        = 24;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 292;
    localparam int MAX_WAIT     = 18;
    localparam int STALL_LIMIT  = 2000;   // cycles with no handshake at all
    localparam int TAIL_CYCLES  = 40;     // longer than a tick with slow sweep

    typedef struct packed {
        logic elapsed;
        logic bad_index;
    } t_status;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [INDEX_W-1:0]  idx;
        logic [COUNT_W-1:0]  val;
        logic                fixed_on;
        t_status             fixed;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    ctb_cmd_if cmd_ch ();
    ctb_rsp_if rsp_ch ();
    ctb_cfg_if cfg_ch ();

    countdown_timer_bank_with_prescaler u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // local copy of the timer state and the two settings
    t_count              fast_cnt [FAST_TIMERS];
    t_count              slow_cnt [SLOW_TIMERS];
    logic [SLOT_W-1:0]   presc_slot;
    logic [RELOAD_W-1:0] presc_reload;

    // responses still owed by the block, oldest first
    t_status pending_status [$];

    // expectation typed into the directed table, travels with the item
    logic    cmd_fixed_on;
    t_status cmd_fixed;

    bit cmd_idle_on;
    bit rsp_idle_on;
    int err_count;
    int rsp_taken;
    int rsp_seen;
    int rsp_hold;
    int idle_cycles;

    t_dir_row dir_rows [0:DIR_N-1];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // apply one command to the local banks and return the status it gives
    function automatic t_status predict_status(input logic [OPCODE_W-1:0] op,
                                               input logic [INDEX_W-1:0] idx,
                                               input t_count val);
        t_status st;
        int      i;
        st = '0;
        case (op)
            OP_TICK: begin
                for (i = 0; i < FAST_TIMERS; i++)
                    if (fast_cnt[i] != 0) fast_cnt[i] = fast_cnt[i] - 1;
                // the prescaler slot hitting zero reloads it and moves the slow bank
                if (int'(presc_slot) < FAST_TIMERS && fast_cnt[presc_slot] == 0) begin
                    fast_cnt[presc_slot] = t_count'(presc_reload);
                    for (i = 0; i < SLOW_TIMERS; i++)
                        if (slow_cnt[i] != 0) slow_cnt[i] = slow_cnt[i] - 1;
                end
            end
            OP_RELOAD_FAST: begin
                if (int'(idx) < FAST_TIMERS) fast_cnt[idx] = val;
                else st.bad_index = 1'b1;
            end
            OP_RELOAD_SLOW: begin
                if (int'(idx) < SLOW_TIMERS) slow_cnt[idx] = val;
                else st.bad_index = 1'b1;
            end
            OP_QUERY_FAST: begin
                if (int'(idx) < FAST_TIMERS) st.elapsed = (fast_cnt[idx] == 0);
                else st = '{elapsed: 1'b1, bad_index: 1'b1};
            end
            OP_QUERY_SLOW: begin
                if (int'(idx) < SLOW_TIMERS) st.elapsed = (slow_cnt[idx] == 0);
                else st = '{elapsed: 1'b1, bad_index: 1'b1};
            end
            default: ;
        endcase
        return st;
    endfunction

    // monitor: model update on every accepted item, in-order response check
    always @(posedge i_clk) begin
        t_status st;
        t_status want;
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                st = predict_status(cmd_ch.opcode, cmd_ch.timer_index, cmd_ch.load_value);
                pending_status.push_back(cmd_fixed_on ? cmd_fixed : st);
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_PRESCALE_SLOT:   presc_slot   = cfg_ch.data[SLOT_W-1:0];
                    CFG_PRESCALE_RELOAD: presc_reload = cfg_ch.data[RELOAD_W-1:0];
                    default: ;
                endcase
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                rsp_taken++;
                if (pending_status.size() == 0) begin
                    $error("response with nothing outstanding: elapsed %0b bad_index %0b",
                           rsp_ch.elapsed, rsp_ch.bad_index);
                    err_count++;
                end else begin
                    want = pending_status.pop_front();
                    if (rsp_ch.elapsed !== want.elapsed) begin
                        $error("elapsed: expected %0b, got %0b", want.elapsed, rsp_ch.elapsed);
                        err_count++;
                    end
                    if (rsp_ch.bad_index !== want.bad_index) begin
                        $error("bad_index: expected %0b, got %0b",
                               want.bad_index, rsp_ch.bad_index);
                        err_count++;
                    end
                end
            end
        end
    end

    // response side back-pressure: a fresh hold per item, counted while valid
    always @(negedge i_clk) begin
        if (rsp_taken != rsp_seen) begin
            rsp_seen = rsp_taken;
            rsp_hold = rsp_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        end
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (rsp_hold != 0) begin
            rsp_ch.ready <= 1'b0;
            if (rsp_ch.valid) rsp_hold--;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // watchdog: ends the run once no channel has moved for too long
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // drive one command item, after a random gap when idling is on
    task automatic send_command(input logic [OPCODE_W-1:0] op,
                                input logic [INDEX_W-1:0] idx,
                                input t_count val,
                                input logic fixed_on,
                                input t_status fixed);
        int gap;
        gap = cmd_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0) begin
            @(negedge i_clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        cmd_ch.valid       <= 1'b1;
        cmd_ch.opcode      <= op;
        cmd_ch.timer_index <= idx;
        cmd_ch.load_value  <= val;
        cmd_fixed_on       <= fixed_on;
        cmd_fixed          <= fixed;
        do @(posedge i_clk); while (!cmd_ch.ready);
    endtask

    task automatic write_register(input t_cfg_reg r, input logic [CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // drop valid and wait until every owed response has come back
    task automatic wait_drained;
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (pending_status.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int                  ph;
        int                  n;
        int                  w;
        logic [OPCODE_W-1:0] op;
        logic [INDEX_W-1:0]  idx;
        t_count              val;
        logic [SLOT_W-1:0]   slot_v;
        logic [RELOAD_W-1:0] reload_v;

        // every input known from time zero
        i_rst_n            = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.opcode      = OP_TICK;
        cmd_ch.timer_index = '0;
        cmd_ch.load_value  = '0;
        rsp_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_PRESCALE_SLOT;
        cfg_ch.data        = '0;
        cmd_fixed_on       = 1'b0;
        cmd_fixed          = '0;
        cmd_idle_on        = 1'b1;
        rsp_idle_on        = 1'b1;
        err_count          = 0;
        rsp_taken          = 0;
        rsp_seen           = 0;
        rsp_hold           = 0;
        idle_cycles        = 0;
        for (n = 0; n < FAST_TIMERS; n++) fast_cnt[n] = '0;
        for (n = 0; n < SLOW_TIMERS; n++) slow_cnt[n] = '0;
        presc_slot   = '0;
        presc_reload = RELOAD_RESET;

        // directed part at the reset settings: slot 0, reload 1000
        dir_rows = '{
            // fresh timers read zero after reset
            '{OP_QUERY_FAST,  4'd0,  32'h0,        1'b1, 2'b10},
            '{OP_QUERY_SLOW,  4'd7,  32'h0,        1'b1, 2'b10},
            '{OP_QUERY_FAST,  4'd15, 32'hFFFFFFFF, 1'b1, 2'b10},
            // slow index past the bank: query reports elapsed, reload is dropped
            '{OP_QUERY_SLOW,  4'd8,  32'h0,        1'b1, 2'b11},
            '{OP_QUERY_SLOW,  4'd15, 32'hFFFFFFFF, 1'b1, 2'b11},
            '{OP_RELOAD_SLOW, 4'd8,  32'd5,        1'b1, 2'b01},
            '{OP_RELOAD_SLOW, 4'd15, 32'hFFFFFFFF, 1'b1, 2'b01},
            // unused opcodes do nothing
            '{OP_SPARE_5,     4'd0,  32'h0,        1'b1, 2'b00},
            '{OP_SPARE_6,     4'd7,  32'hAAAAAAAA, 1'b1, 2'b00},
            '{OP_SPARE_7,     4'd15, 32'hFFFFFFFF, 1'b1, 2'b00},
            // full-scale and one-count loads
            '{OP_RELOAD_FAST, 4'd15, 32'hFFFFFFFF, 1'b1, 2'b00},
            '{OP_QUERY_FAST,  4'd15, 32'h0,        1'b0, 2'b00},
            '{OP_RELOAD_SLOW, 4'd7,  32'hFFFFFFFF, 1'b1, 2'b00},
            '{OP_RELOAD_FAST, 4'd1,  32'd1,        1'b1, 2'b00},
            // prescaler already at zero: reload to 1000, slow bank steps
            '{OP_TICK,        4'd0,  32'h0,        1'b1, 2'b00},
            '{OP_QUERY_FAST,  4'd1,  32'h0,        1'b0, 2'b00},
            '{OP_QUERY_FAST,  4'd0,  32'h0,        1'b0, 2'b00},
            '{OP_RELOAD_SLOW, 4'd0,  32'd1,        1'b1, 2'b00},
            '{OP_TICK,        4'd15, 32'hFFFFFFFF, 1'b1, 2'b00},
            '{OP_QUERY_SLOW,  4'd0,  32'h0,        1'b0, 2'b00},
            // force the prescaler to zero so the next tick moves the slow bank
            '{OP_RELOAD_FAST, 4'd0,  32'h0,        1'b1, 2'b00},
            '{OP_TICK,        4'd0,  32'h0,        1'b1, 2'b00},
            '{OP_QUERY_SLOW,  4'd0,  32'h0,        1'b0, 2'b00},
            '{OP_QUERY_SLOW,  4'd7,  32'h0,        1'b0, 2'b00}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < DIR_N; n++)
            send_command(dir_rows[n].op, dir_rows[n].idx, dir_rows[n].val,
                         dir_rows[n].fixed_on, dir_rows[n].fixed);
        wait_drained();

        for (ph = 0; ph < PHASES; ph++) begin
            // settings per phase, extremes of both registers included
            case (ph)
                0: begin slot_v = 4'd0;              reload_v = 16'd1;     end
                1: begin slot_v = 4'd15;             reload_v = 16'd0;     end
                2: begin slot_v = SLOT_W'($urandom_range(0, 15)); reload_v = 16'd2; end
                3: begin slot_v = 4'd7;              reload_v = 16'hFFFF;  end
                4: begin slot_v = SLOT_W'($urandom_range(0, 15)); reload_v = 16'd3; end
                default: begin
                    slot_v   = SLOT_W'($urandom_range(0, 15));
                    reload_v = RELOAD_W'($urandom_range(1, 6));
                end
            endcase
            // upper data bits are don't-care for the slot register
            write_register(CFG_PRESCALE_SLOT, {12'($urandom), slot_v});
            write_register(CFG_PRESCALE_RELOAD, reload_v);

            // one phase with no idling at all, two with one side busy
            cmd_idle_on = (ph != 2) && (ph != 1);
            rsp_idle_on = (ph != 2) && (ph != 3);

            for (n = 0; n < PHASE_ITEMS; n++) begin
                w = $urandom_range(0, 99);
                if (w < 38)      op = OP_TICK;
                else if (w < 52) op = OP_RELOAD_FAST;
                else if (w < 64) op = OP_RELOAD_SLOW;
                else if (w < 78) op = OP_QUERY_FAST;
                else if (w < 95) op = OP_QUERY_SLOW;
                else             op = OPCODE_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));

                // slow bank ops mostly in range, some past the end
                if ((op == OP_RELOAD_SLOW || op == OP_QUERY_SLOW) && SLOW_TIMERS < 16 &&
                    $urandom_range(0, 99) >= 85)
                    idx = INDEX_W'($urandom_range(SLOW_TIMERS, 15));
                else if (op == OP_RELOAD_SLOW || op == OP_QUERY_SLOW)
                    idx = INDEX_W'($urandom_range(0, SLOW_TIMERS - 1));
                else
                    idx = INDEX_W'($urandom_range(0, 15));

                // small counts so timers actually run out between queries
                w = $urandom_range(0, 9);
                if (w < 6)       val = $urandom_range(0, 6);
                else if (w == 6) val = $urandom_range(0, 40);
                else if (w == 7) val = $urandom();
                else if (w == 8) val = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'd1;
                else             val = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0,
                                        16'($urandom_range(0, 8))};

                send_command(op, idx, val, 1'b0, '0);
            end
            wait_drained();
        end

        // let any stray response show up before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
